>>> hw/rtl/bicubic_bezier_patch_eval_unit_assert.svh
// Assertion macros for the Bezier patch evaluator.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef BICUBIC_BEZIER_PATCH_EVAL_UNIT_ASSERT_SVH
`define BICUBIC_BEZIER_PATCH_EVAL_UNIT_ASSERT_SVH

// Same-cycle implication
`define BBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bbpe_pkg.sv
// Package for the Bezier patch evaluator: sizes, codes, sequencer types
// and rounding helpers. No dependencies.
`default_nettype none
package bbpe_pkg;

    localparam int NUM_PATCHES = 32;
    localparam int NUM_POINTS  = 512;
    localparam int TBL_DEPTH   = NUM_PATCHES * 16;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int PT_AW       = $clog2(NUM_POINTS);

    localparam logic [1:0] CMD_LOAD_PT  = 2'd0;
    localparam logic [1:0] CMD_LOAD_IDX = 2'd1;
    localparam logic [1:0] CMD_EVAL     = 2'd2;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WGT, ST_TBL, ST_PNT, ST_MUL, ST_RWAIT, ST_RFIN,
        ST_VMUL, ST_VWAIT, ST_VFIN, ST_NEXT, ST_AB, ST_CROSS, ST_CWAIT, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        DST_T2, DST_S2, DST_W1X, DST_W3X, DST_ACC, DST_NSET, DST_NSUB
    } t_dst;

    // Tag travelling with the registered product
    typedef struct packed {
        logic       vld;
        t_dst       dst;
        logic [1:0] idx;
        logic       wsel;
        logic [1:0] crd;
    } t_tag;

    // Round half up from Q16.46 to Q16.16 and saturate
    function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] a);
        logic signed [63:0] t;
        t = (a + 64'sd536870912) >>> 30;
        if (t > 64'sd2147483647)       rnd_sat = 32'sh7FFFFFFF;
        else if (t < -64'sd2147483648) rnd_sat = 32'sh80000000;
        else                           rnd_sat = t[31:0];
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] a);
        if (a > 33'sd2147483647)       sat33 = 32'sh7FFFFFFF;
        else if (a < -33'sd2147483648) sat33 = 32'sh80000000;
        else                           sat33 = a[31:0];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bicubic_bezier_patch_eval_unit.sv
// Bicubic Bezier patch evaluator, top level and only module.
// Depends on bbpe_pkg and bicubic_bezier_patch_eval_unit_assert.svh.
//
// Use: items arrive on the in channel (i_in_valid / o_in_ready). A load
// point or load index item gives no result. An
// evaluate item gives one result on the out channel (o_out_valid /
// i_out_ready); an evaluate for a patch out of range gives none.
// The config channel (i_cfg_valid / o_cfg_ready) writes the difference
// offset, always ready; write it only while the block is idle.
// One shared 34x34 multiplier does all multiplications. Each of up to
// six surface evaluations computes the weights, blends four rows of four
// points, then blends the column curve and stores it. An evaluate runs
// six surface evaluations and a cross product for the normal, or three
// evaluations when the patch is degenerate. o_in_ready is
// low meanwhile.
// The result sits in an output register; the next item is taken while it
// waits, and a finished evaluate holds until that register is free.
// Reset: synchronous, active low; the offset returns to 66, the output
// goes empty. The point store and index table are not cleared.
`default_nettype none
`include "bicubic_bezier_patch_eval_unit_assert.svh"
module bicubic_bezier_patch_eval_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [12:0]         i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [1:0]          i_command,
    input  wire  [8:0]          i_point_index,
    input  wire  [4:0]          i_patch_number,
    input  wire  [3:0]          i_slot,
    input  wire  signed [31:0]  i_coord_x,
    input  wire  signed [31:0]  i_coord_y,
    input  wire  signed [31:0]  i_coord_z,
    input  wire  [16:0]         i_param_u,
    input  wire  [16:0]         i_param_v,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic signed [31:0]  o_point_x,
    output logic signed [31:0]  o_point_y,
    output logic signed [31:0]  o_point_z,
    output logic signed [63:0]  o_normal_x,
    output logic signed [63:0]  o_normal_y,
    output logic signed [63:0]  o_normal_z,
    output logic                o_degenerate_flag
);

    // Memories
    logic [95:0] r_pt_mem [bbpe_pkg::NUM_POINTS];
    logic [8:0]  r_tbl_mem [bbpe_pkg::TBL_DEPTH];
    logic [95:0] r_pt_q;
    logic [8:0]  r_tbl_q;
    logic        r_pt_ok;

    bbpe_pkg::t_state r_state, n_state;
    logic [12:0] r_d;
    logic [16:0] r_u, r_v;
    logic [4:0]  r_patch;
    logic [2:0]  r_pass;
    logic [3:0]  r_k;
    logic [1:0]  r_i, r_j, r_c;
    logic        r_deg;
    logic        r_ov;
    logic [32:0] r_t2, r_s2;
    logic [30:0] r_w [2][4];
    logic signed [63:0] r_acc [3];
    logic signed [31:0] r_rows [3][4];
    logic signed [31:0] r_res [6][3];
    logic signed [31:0] r_a [3];
    logic signed [31:0] r_b [3];
    logic signed [63:0] r_n [3];
    logic signed [63:0] r_prod;
    bbpe_pkg::t_tag r_tag, n_tag;

    logic signed [33:0] m_a, m_b;
    logic signed [67:0] m_full;
    logic in_acc, ev_ok, out_free;
    logic [bbpe_pkg::TBL_AW-1:0] tbl_ra, tbl_wa;
    logic [16:0] uu, vv, pu, pv, wt, ws;
    logic [2:0]  wk;
    logic        wsel;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == bbpe_pkg::ST_IDLE);
    assign o_out_valid = r_ov;
    assign in_acc      = i_in_valid && o_in_ready;
    assign ev_ok       = (32'(i_patch_number) < bbpe_pkg::NUM_PATCHES);
    assign out_free    = !r_ov || i_out_ready;

    // Pass parameters: step moved back near 1.0
    always_comb begin
        uu = (r_u >= (bbpe_pkg::ONE_Q16 - 17'(r_d))) ? r_u - 17'(r_d) : r_u;
        vv = (r_v >= (bbpe_pkg::ONE_Q16 - 17'(r_d))) ? r_v - 17'(r_d) : r_v;
        case (r_pass)
            3'd0:    begin pu = r_u;                pv = r_v; end
            3'd1:    begin pu = 17'd0;              pv = r_v; end
            3'd2:    begin pu = bbpe_pkg::ONE_Q16;  pv = r_v; end
            3'd3:    begin pu = uu;                 pv = vv; end
            3'd4:    begin pu = uu + 17'(r_d);      pv = vv; end
            default: begin pu = uu;                 pv = vv + 17'(r_d); end
        endcase
        wsel = (r_k >= 4'd6);
        wk   = wsel ? 3'(r_k - 4'd6) : r_k[2:0];
        wt   = wsel ? pv : pu;
        ws   = bbpe_pkg::ONE_Q16 - wt;
    end

    assign tbl_ra = bbpe_pkg::TBL_AW'(32'(r_patch) * 16 + 32'({r_i, r_j}));
    assign tbl_wa = bbpe_pkg::TBL_AW'(32'(i_patch_number) * 16 + 32'(i_slot));

    // Sequencer: next state and multiplier issue
    always_comb begin
        n_state = r_state;
        m_a     = '0;
        m_b     = '0;
        n_tag   = '{vld: 1'b0, dst: bbpe_pkg::DST_ACC, idx: 2'd0, wsel: 1'b0, crd: 2'd0};
        case (r_state)
            bbpe_pkg::ST_IDLE: begin
                if (in_acc && i_command == bbpe_pkg::CMD_EVAL && ev_ok)
                    n_state = bbpe_pkg::ST_WGT;
            end
            bbpe_pkg::ST_WGT: begin
                n_tag.vld  = 1'b1;
                n_tag.wsel = wsel;
                case (wk)
                    3'd0: begin m_a = 34'(wt); m_b = 34'(wt); n_tag.dst = bbpe_pkg::DST_T2; end
                    3'd1: begin m_a = 34'(ws); m_b = 34'(ws); n_tag.dst = bbpe_pkg::DST_S2; end
                    3'd2: begin
                        m_a = 34'(r_t2); m_b = 34'(wt);
                        n_tag.dst = bbpe_pkg::DST_W1X; n_tag.idx = 2'd3;
                    end
                    3'd3: begin
                        m_a = 34'(r_s2); m_b = 34'(ws);
                        n_tag.dst = bbpe_pkg::DST_W1X; n_tag.idx = 2'd0;
                    end
                    3'd4: begin
                        m_a = 34'(r_s2); m_b = 34'(wt);
                        n_tag.dst = bbpe_pkg::DST_W3X; n_tag.idx = 2'd1;
                    end
                    default: begin
                        m_a = 34'(r_t2); m_b = 34'(ws);
                        n_tag.dst = bbpe_pkg::DST_W3X; n_tag.idx = 2'd2;
                    end
                endcase
                if (r_k == 4'd11) n_state = bbpe_pkg::ST_TBL;
            end
            bbpe_pkg::ST_TBL: n_state = bbpe_pkg::ST_PNT;
            bbpe_pkg::ST_PNT: n_state = bbpe_pkg::ST_MUL;
            bbpe_pkg::ST_MUL: begin
                case (r_c)
                    2'd0:    m_a = 34'(signed'(r_pt_q[31:0]));
                    2'd1:    m_a = 34'(signed'(r_pt_q[63:32]));
                    default: m_a = 34'(signed'(r_pt_q[95:64]));
                endcase
                if (!r_pt_ok) m_a = '0;
                m_b       = 34'(r_w[0][r_j]);
                n_tag.vld = 1'b1;
                n_tag.dst = bbpe_pkg::DST_ACC;
                n_tag.crd = r_c;
                if (r_c == 2'd2)
                    n_state = (r_j == 2'd3) ? bbpe_pkg::ST_RWAIT : bbpe_pkg::ST_TBL;
            end
            bbpe_pkg::ST_RWAIT: n_state = bbpe_pkg::ST_RFIN;
            bbpe_pkg::ST_RFIN:
                n_state = (r_i == 2'd3) ? bbpe_pkg::ST_VMUL : bbpe_pkg::ST_TBL;
            bbpe_pkg::ST_VMUL: begin
                m_a       = 34'(r_rows[r_k[3:2]][r_k[1:0]]);
                m_b       = 34'(r_w[1][r_k[1:0]]);
                n_tag.vld = 1'b1;
                n_tag.dst = bbpe_pkg::DST_ACC;
                n_tag.crd = r_k[3:2];
                if (r_k == 4'd11) n_state = bbpe_pkg::ST_VWAIT;
            end
            bbpe_pkg::ST_VWAIT: n_state = bbpe_pkg::ST_VFIN;
            bbpe_pkg::ST_VFIN:  n_state = bbpe_pkg::ST_NEXT;
            bbpe_pkg::ST_NEXT: begin
                if (r_pass == 3'd2 && r_res[1][0] == r_res[2][0] &&
                        r_res[1][1] == r_res[2][1] && r_res[1][2] == r_res[2][2])
                    n_state = bbpe_pkg::ST_DONE;
                else if (r_pass == 3'd5)
                    n_state = bbpe_pkg::ST_AB;
                else
                    n_state = bbpe_pkg::ST_WGT;
            end
            bbpe_pkg::ST_AB: n_state = bbpe_pkg::ST_CROSS;
            bbpe_pkg::ST_CROSS: begin
                n_tag.vld = 1'b1;
                n_tag.dst = r_k[0] ? bbpe_pkg::DST_NSUB : bbpe_pkg::DST_NSET;
                n_tag.idx = 2'(r_k[2:1]);
                case (r_k[2:0])
                    3'd0:    begin m_a = 34'(r_a[1]); m_b = 34'(r_b[2]); end
                    3'd1:    begin m_a = 34'(r_a[2]); m_b = 34'(r_b[1]); end
                    3'd2:    begin m_a = 34'(r_a[2]); m_b = 34'(r_b[0]); end
                    3'd3:    begin m_a = 34'(r_a[0]); m_b = 34'(r_b[2]); end
                    3'd4:    begin m_a = 34'(r_a[0]); m_b = 34'(r_b[1]); end
                    default: begin m_a = 34'(r_a[1]); m_b = 34'(r_b[0]); end
                endcase
                if (r_k == 4'd5) n_state = bbpe_pkg::ST_CWAIT;
            end
            bbpe_pkg::ST_CWAIT: n_state = bbpe_pkg::ST_DONE;
            bbpe_pkg::ST_DONE: if (out_free) n_state = bbpe_pkg::ST_IDLE;
            default: n_state = bbpe_pkg::ST_IDLE;
        endcase
    end

    assign m_full = m_a * m_b;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bbpe_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == bbpe_pkg::CMD_LOAD_PT &&
                32'(i_point_index) < bbpe_pkg::NUM_POINTS)
            r_pt_mem[bbpe_pkg::PT_AW'(i_point_index)] <= {i_coord_z, i_coord_y, i_coord_x};
        if (r_state == bbpe_pkg::ST_PNT)
            r_pt_q <= r_pt_mem[bbpe_pkg::PT_AW'(r_tbl_q)];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == bbpe_pkg::CMD_LOAD_IDX && ev_ok)
            r_tbl_mem[tbl_wa] <= i_point_index;
        if (r_state == bbpe_pkg::ST_TBL)
            r_tbl_q <= r_tbl_mem[tbl_ra];
    end

    // Control counters, config and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d    <= 13'd66;
            r_ov   <= 1'b0;
            r_pass <= 3'd0;
            r_k    <= 4'd0;
            r_i    <= 2'd0;
            r_j    <= 2'd0;
            r_c    <= 2'd0;
            r_deg  <= 1'b0;
            r_tag  <= '{vld: 1'b0, dst: bbpe_pkg::DST_ACC, idx: 2'd0, wsel: 1'b0, crd: 2'd0};
        end else begin
            r_tag <= n_tag;
            if (i_cfg_valid) r_d <= i_cfg_data;
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            case (r_state)
                bbpe_pkg::ST_IDLE: begin
                    r_pass <= 3'd0;
                    r_k    <= 4'd0;
                    r_i    <= 2'd0;
                    r_j    <= 2'd0;
                    r_c    <= 2'd0;
                    r_deg  <= 1'b0;
                end
                bbpe_pkg::ST_WGT:   r_k <= (r_k == 4'd11) ? 4'd0 : r_k + 4'd1;
                bbpe_pkg::ST_MUL: begin
                    r_c <= (r_c == 2'd2) ? 2'd0 : r_c + 2'd1;
                    if (r_c == 2'd2) r_j <= r_j + 2'd1;
                end
                bbpe_pkg::ST_RFIN:  r_i <= r_i + 2'd1;
                bbpe_pkg::ST_VMUL:  r_k <= (r_k == 4'd11) ? 4'd0 : r_k + 4'd1;
                bbpe_pkg::ST_NEXT: begin
                    if (n_state == bbpe_pkg::ST_DONE) r_deg <= 1'b1;
                    if (n_state == bbpe_pkg::ST_WGT)  r_pass <= r_pass + 3'd1;
                end
                bbpe_pkg::ST_CROSS: r_k <= (r_k == 4'd5) ? 4'd0 : r_k + 4'd1;
                bbpe_pkg::ST_DONE:  if (out_free) r_ov <= 1'b1;
                default: ;
            endcase
        end
    end

    // Datapath: product register, write-back and pass results
    always_ff @(posedge i_clk) begin
        logic [63:0] w3;
        w3 = 64'(r_prod) + (64'(r_prod) << 1) + 64'd131072;
        r_prod <= m_full[63:0];
        if (r_state == bbpe_pkg::ST_PNT)
            r_pt_ok <= (32'(r_tbl_q) < bbpe_pkg::NUM_POINTS);
        if (in_acc) begin
            r_u     <= (i_param_u > bbpe_pkg::ONE_Q16) ? bbpe_pkg::ONE_Q16 : i_param_u;
            r_v     <= (i_param_v > bbpe_pkg::ONE_Q16) ? bbpe_pkg::ONE_Q16 : i_param_v;
            r_patch <= i_patch_number;
            for (int c = 0; c < 3; c++) r_acc[c] <= '0;
        end
        if (r_tag.vld) begin
            case (r_tag.dst)
                bbpe_pkg::DST_T2:  r_t2 <= r_prod[32:0];
                bbpe_pkg::DST_S2:  r_s2 <= r_prod[32:0];
                bbpe_pkg::DST_W1X: r_w[r_tag.wsel][r_tag.idx] <=
                                       31'((64'(r_prod) + 64'd131072) >> 18);
                bbpe_pkg::DST_W3X: r_w[r_tag.wsel][r_tag.idx] <= w3[48:18];
                bbpe_pkg::DST_ACC: r_acc[r_tag.crd] <= r_acc[r_tag.crd] + r_prod;
                bbpe_pkg::DST_NSET: r_n[r_tag.idx] <= r_prod;
                bbpe_pkg::DST_NSUB: r_n[r_tag.idx] <= r_n[r_tag.idx] - r_prod;
                default: ;
            endcase
        end
        // Row and column curve results
        if (r_state == bbpe_pkg::ST_RFIN) begin
            for (int c = 0; c < 3; c++) begin
                r_rows[c][r_i] <= bbpe_pkg::rnd_sat(r_acc[c]);
                r_acc[c]       <= '0;
            end
        end
        if (r_state == bbpe_pkg::ST_VFIN) begin
            for (int c = 0; c < 3; c++) begin
                r_res[r_pass][c] <= bbpe_pkg::rnd_sat(r_acc[c]);
                r_acc[c]         <= '0;
            end
        end
        // Forward differences
        if (r_state == bbpe_pkg::ST_AB) begin
            for (int c = 0; c < 3; c++) begin
                r_a[c] <= bbpe_pkg::sat33(33'(r_res[4][c]) - 33'(r_res[3][c]));
                r_b[c] <= bbpe_pkg::sat33(33'(r_res[5][c]) - 33'(r_res[3][c]));
            end
        end
        // Output register
        if (r_state == bbpe_pkg::ST_DONE && out_free) begin
            o_point_x         <= r_res[0][0];
            o_point_y         <= r_res[0][1];
            o_point_z         <= r_res[0][2];
            o_degenerate_flag <= r_deg;
            o_normal_x        <= r_deg ? 64'sd0 : r_n[0];
            o_normal_y        <= r_deg ? 64'sd0 : r_n[1];
            o_normal_z        <= r_deg ? 64'sh1_0000_0000 : r_n[2];
        end
    end

    // Assertions
    `BBP_ASSERT_NOW(a_deg_normal, r_ov && o_degenerate_flag, o_normal_x == 64'sd0 && o_normal_y == 64'sd0 && o_normal_z == 64'sh1_0000_0000, "degenerate result without unit z normal")
    `BBP_ASSERT_NEXT(a_eval_start, in_acc && i_command == bbpe_pkg::CMD_EVAL && ev_ok, r_state == bbpe_pkg::ST_WGT, "evaluate did not start")
    `BBP_ASSERT_NEXT(a_done_hold, r_state == bbpe_pkg::ST_DONE && r_ov && !i_out_ready, r_state == bbpe_pkg::ST_DONE && r_ov, "result overwrote a pending transfer")
    `BBP_ASSERT_NOW(a_pass_range, r_state != bbpe_pkg::ST_IDLE, r_pass <= 3'd5, "pass counter out of range")

endmodule
`default_nettype wire

>>> tb/sv/bicubic_bezier_patch_eval_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the Bezier patch evaluator: loads points and index
// tables, evaluates patches and checks each result against its own predictor.
// Depends on bbpe_pkg and bicubic_bezier_patch_eval_unit.
`default_nettype none
module bicubic_bezier_patch_eval_unit_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         SETTLE_CYCLES = 800;

    typedef struct {
        logic [1:0]         cmd;
        logic [8:0]         pidx;
        logic [4:0]         patch;
        logic [3:0]         slot;
        logic signed [31:0] x, y, z;
        logic [16:0]        u, v;
    } t_patch_item;

    typedef struct {
        longint px, py, pz;
        longint nx, ny, nz;
        logic   degen;
    } t_surface_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [12:0] i_cfg_data = '0;
    logic o_cfg_ready;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [1:0] i_command = '0;
    logic [8:0] i_point_index = '0;
    logic [4:0] i_patch_number = '0;
    logic [3:0] i_slot = '0;
    logic signed [31:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic [16:0] i_param_u = '0, i_param_v = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [31:0] o_point_x, o_point_y, o_point_z;
    logic signed [63:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_degenerate_flag;

    bicubic_bezier_patch_eval_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_command(i_command), .i_point_index(i_point_index),
        .i_patch_number(i_patch_number), .i_slot(i_slot),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_param_u(i_param_u), .i_param_v(i_param_v),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_point_x(o_point_x), .o_point_y(o_point_y), .o_point_z(o_point_z),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_degenerate_flag(o_degenerate_flag)
    );

    // Clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state, updated on each accepted transfer
    longint     pred_pts [bbpe_pkg::NUM_POINTS][3];
    logic [8:0] pred_tbl [bbpe_pkg::TBL_DEPTH];
    int unsigned diff_step = 66;

    // Generator bookkeeping: what has been written so far
    bit pt_loaded [bbpe_pkg::NUM_POINTS];
    bit ent_loaded [bbpe_pkg::TBL_DEPTH];
    int loaded_pts [$];

    t_patch_item     pending_q [$];
    t_surface_result expected_q [$];
    t_patch_item     cur_item;
    int  fail_count = 0;
    bit  quiet = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;

    function automatic longint sat_word(input longint a);
        if (a > 64'sd2147483647) return 64'sd2147483647;
        if (a < -64'sd2147483648) return -64'sd2147483648;
        return a;
    endfunction

    // Bernstein weights rounded half up from Q0.48 to Q0.30
    function automatic void bern_weights(input int unsigned t, output longint w[4]);
        longint unsigned tt, ss;
        longint unsigned r [4];
        tt = t;
        ss = 64'd65536 - tt;
        r[0] = ss * ss * ss;
        r[1] = 3 * tt * ss * ss;
        r[2] = 3 * tt * tt * ss;
        r[3] = tt * tt * tt;
        for (int k = 0; k < 4; k++) w[k] = longint'((r[k] + 64'd131072) >> 18);
    endfunction

    function automatic longint cubic_blend(input longint w[4], input longint p[4]);
        longint acc;
        acc = 0;
        for (int k = 0; k < 4; k++) acc += p[k] * w[k];
        return sat_word((acc + 64'sd536870912) >>> 30);
    endfunction

    function automatic void patch_point(input int unsigned u, input int unsigned v,
                                        input int unsigned patch, output longint pt[3]);
        longint wu [4], wv [4], ops [4];
        longint rows [3][4];
        logic [8:0] addr;
        bern_weights(u, wu);
        bern_weights(v, wv);
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    addr = pred_tbl[patch * 16 + 4 * i + j];
                    ops[j] = pred_pts[addr][c];
                end
                rows[c][i] = cubic_blend(wu, ops);
            end
            pt[c] = cubic_blend(wv, rows[c]);
        end
    endfunction

    // Apply one accepted item to the predictor; queue a result for an evaluate
    function automatic void absorb_item(input t_patch_item it);
        t_surface_result r;
        longint p [3], e0 [3], e1 [3], p0 [3], pu [3], pv [3], a [3], b [3];
        int unsigned u, v, uu, vv, d;
        case (it.cmd)
            bbpe_pkg::CMD_LOAD_PT: begin
                pred_pts[it.pidx][0] = it.x;
                pred_pts[it.pidx][1] = it.y;
                pred_pts[it.pidx][2] = it.z;
            end
            bbpe_pkg::CMD_LOAD_IDX: pred_tbl[it.patch * 16 + it.slot] = it.pidx;
            bbpe_pkg::CMD_EVAL: begin
                u = (it.u > bbpe_pkg::ONE_Q16) ? 65536 : it.u;
                v = (it.v > bbpe_pkg::ONE_Q16) ? 65536 : it.v;
                d = diff_step;
                patch_point(u, v, it.patch, p);
                patch_point(0, v, it.patch, e0);
                patch_point(65536, v, it.patch, e1);
                r.degen = (e0[0] == e1[0]) && (e0[1] == e1[1]) && (e0[2] == e1[2]);
                if (r.degen) begin
                    r.nx = 0;
                    r.ny = 0;
                    r.nz = 64'sd1 <<< 32;
                end else begin
                    uu = (u >= 65536 - d) ? u - d : u;
                    vv = (v >= 65536 - d) ? v - d : v;
                    patch_point(uu, vv, it.patch, p0);
                    patch_point(uu + d, vv, it.patch, pu);
                    patch_point(uu, vv + d, it.patch, pv);
                    for (int c = 0; c < 3; c++) begin
                        a[c] = sat_word(pu[c] - p0[c]);
                        b[c] = sat_word(pv[c] - p0[c]);
                    end
                    r.nx = a[1] * b[2] - a[2] * b[1];
                    r.ny = a[2] * b[0] - a[0] * b[2];
                    r.nz = a[0] * b[1] - a[1] * b[0];
                end
                r.px = p[0];
                r.py = p[1];
                r.pz = p[2];
                expected_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // Input driver: holds the payload until the transfer, then maybe idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !o_in_ready)) begin
            if (i_in_valid) begin
                absorb_item(cur_item);
                if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 5);
            end
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur_item = pending_q.pop_front();
                i_command      <= cur_item.cmd;
                i_point_index  <= cur_item.pidx;
                i_patch_number <= cur_item.patch;
                i_slot         <= cur_item.slot;
                i_coord_x      <= cur_item.x;
                i_coord_y      <= cur_item.y;
                i_coord_z      <= cur_item.z;
                i_param_u      <= cur_item.u;
                i_param_v      <= cur_item.v;
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stalls
    always @(posedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 5);
        end
    end

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Result monitor
    always @(posedge i_clk) begin
        t_surface_result r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                r = expected_q.pop_front();
                check_field("point_x", r.px, longint'(o_point_x));
                check_field("point_y", r.py, longint'(o_point_y));
                check_field("point_z", r.pz, longint'(o_point_z));
                check_field("normal_x", r.nx, o_normal_x);
                check_field("normal_y", r.ny, o_normal_y);
                check_field("normal_z", r.nz, o_normal_z);
                check_field("degenerate_flag", longint'(r.degen),
                            longint'(o_degenerate_flag));
            end
        end
    end

    // Stimulus construction
    function automatic t_patch_item blank_item(input logic [1:0] cmd);
        t_patch_item it;
        it.cmd = cmd;
        it.pidx = 9'($urandom);
        it.patch = 5'($urandom);
        it.slot = 4'($urandom);
        it.x = $urandom;
        it.y = $urandom;
        it.z = $urandom;
        it.u = 17'($urandom);
        it.v = 17'($urandom);
        return it;
    endfunction

    function automatic void push_point(input int addr, input logic signed [31:0] x,
                                       input logic signed [31:0] y,
                                       input logic signed [31:0] z);
        t_patch_item it;
        it = blank_item(bbpe_pkg::CMD_LOAD_PT);
        it.pidx = 9'(addr);
        it.x = x;
        it.y = y;
        it.z = z;
        pending_q.push_back(it);
        if (!pt_loaded[addr]) loaded_pts.push_back(addr);
        pt_loaded[addr] = 1'b1;
    endfunction

    function automatic void push_entry(input int patch, input int slot, input int addr);
        t_patch_item it;
        it = blank_item(bbpe_pkg::CMD_LOAD_IDX);
        it.patch = 5'(patch);
        it.slot = 4'(slot);
        it.pidx = 9'(addr);
        pending_q.push_back(it);
        ent_loaded[patch * 16 + slot] = 1'b1;
    endfunction

    function automatic void push_eval(input int patch, input int u, input int v);
        t_patch_item it;
        it = blank_item(bbpe_pkg::CMD_EVAL);
        it.patch = 5'(patch);
        it.u = 17'(u);
        it.v = 17'(v);
        pending_q.push_back(it);
    endfunction

    function automatic bit patch_ready(input int patch);
        for (int s = 0; s < 16; s++) if (!ent_loaded[patch * 16 + s]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int rand_param();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 131071);
            1: return 65536 - $urandom_range(0, 8300);
            2: return $urandom_range(0, 1) ? 0 : 65536;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed(32'($urandom_range(0, 1 << 19))) - (1 << 18);
        endcase
    endfunction

    // Random stimulus, mostly load-then-evaluate sequences; returns items added, not counting unused-command items
    function automatic int add_random_sequence();
        int n, patch, first_col;
        n = 0;
        if ($urandom_range(0, 9) == 0) begin
            pending_q.push_back(blank_item(CMD_UNUSED));
            patch = $urandom_range(0, bbpe_pkg::NUM_PATCHES - 1);
            if (patch_ready(patch)) begin
                push_eval(patch, rand_param(), rand_param());
                n++;
            end
            return n;
        end
        patch = $urandom_range(0, bbpe_pkg::NUM_PATCHES - 1);
        for (int k = $urandom_range(1, 4); k > 0; k--) begin
            push_point($urandom_range(0, bbpe_pkg::NUM_POINTS - 1), rand_coord(),
                       rand_coord(), rand_coord());
            n++;
        end
        // Copy column 0 into column 3 now and then for a collapsed edge
        for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
                if (col == 0) first_col = loaded_pts[$urandom_range(0, loaded_pts.size() - 1)];
                push_entry(patch, 4 * row + col,
                           (col == 3 && $urandom_range(0, 3) == 0) ? first_col
                           : (col == 0) ? first_col
                           : loaded_pts[$urandom_range(0, loaded_pts.size() - 1)]);
                n++;
            end
        end
        for (int k = $urandom_range(1, 3); k > 0; k--) begin
            push_eval(patch, rand_param(), rand_param());
            n++;
        end
        return n;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() > 0 || i_in_valid || expected_q.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_step(input logic [12:0] d);
        wait_drained();
        // margin before the register write
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        diff_step = d;
    endtask

    initial begin
        int added;
        logic [12:0] steps [5];
        steps = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'($urandom_range(1, 4096))};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme points, a patch with a collapsed edge, edge parameters
        push_point(0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0);
        push_point(1, 32'sh80000000, 32'sh7FFFFFFF, -32'sh1);
        push_point(2, 32'sh00010000, 32'sh00020000, 32'shFFFE0000);
        push_point(bbpe_pkg::NUM_POINTS - 1, 32'sh1, -32'sh1, 32'sh12345678);
        for (int s = 0; s < 16; s++)
            push_entry(0, s, ((s % 4) == 3) ? (s / 4) % 3 : (s / 4 + s % 4) % 3);
        push_eval(0, 0, 0);
        push_eval(0, 65536, 65536);
        push_eval(0, 131071, 0);
        push_eval(0, 32768, 65535);
        push_eval(0, 0, 131071);
        pending_q.push_back(blank_item(CMD_UNUSED));

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_step(steps[ph - 1]);
            if (ph == 5) quiet = 1'b1;
            added = 0;
            while (added < 158) added += add_random_sequence();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Run limit
    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
